[rtl/mgwa_pkg.sv]
// shared types and constants for the median gated window average
package mgwa_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DIFF_W   = SAMPLE_W + 1;

   localparam logic [SAMPLE_W-1:0] MAX_DEV_RESET = 16'd100;

   // window storage control from the sequencer
   typedef struct packed {
      logic shift_in;
      logic rotate;
   } win_ctl_type;

   // shared subtractor result
   typedef struct packed {
      logic                       neg;
      logic                       zero;
      logic        [SAMPLE_W-1:0] mag;
      logic signed [DIFF_W-1:0]   diff;
   } alu_res_type;

endpackage

[rtl/median_gated_window_average.sv]
// top level: outlier rejecting moving average around the window median
//
// usage
//   req channel: one beat per sensor sample, req_tdata holds the signed sample
//   rsp channel: exactly one beat per req beat, in order; rsp_tuser is the
//     valid flag of the smoothed value, rsp_tdata the value (zero if invalid)
//   csr port: csr_wr_en writes max_deviation in one cycle, write only while idle
//   the first WINDOW samples only fill the window and return the held result
//   (invalid, zero after reset); later samples shift the window and re-evaluate
// sequencing
//   a filling sample: from idle to the output state, which registers the rsp
//   beat once the output is free; a full-window sample passes the rank and
//   gate states and, unless every sample is rejected, the divide, the single
//   shared subtractor doing rank count, deviation gate and restoring divide in turn
//   one sample at a time: req_tready is high only while the sequencer is idle
// reset
//   synchronous, clears the fill state, the held result and max_deviation (100)
// stall
//   a pending rsp beat holds while rsp_tready is low; the next sample may be
//   taken and evaluated meanwhile, its result waits until the output frees
module median_gated_window_average import mgwa_pkg::*; #(
   parameter int WINDOW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,    // [15:0] sample
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,    // [15:0] smoothed_value
   output logic                rsp_tuser,    // [0] result_valid
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data   // [15:0] max_deviation
);

   localparam int MID     = WINDOW / 2;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int STEP_W  = $clog2(WINDOW + 1);
   localparam int PASS_W  = $clog2(WINDOW);
   localparam int SUM_W   = DIFF_W + $clog2(WINDOW);
   localparam int DSTEP_W = $clog2(SUM_W);
   localparam int REM_W   = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RANK,
      ST_GATE,
      ST_DIV_SETUP,
      ST_DIV,
      ST_DIV_FIX,
      ST_OUT
   } state_type;

   // control state
   state_type            state_ff,      state_in;
   logic [PASS_W-1:0]    fill_ff,       fill_in;
   logic                 full_ff,       full_in;
   logic [PASS_W-1:0]    pass_ff,       pass_in;
   logic [STEP_W-1:0]    step_ff,       step_in;
   logic [DSTEP_W-1:0]   dstep_ff,      dstep_in;
   logic                 held_valid_ff, held_valid_in;
   logic [SAMPLE_W-1:0]  held_value_ff, held_value_in;
   logic [SAMPLE_W-1:0]  max_dev_ff,    max_dev_in;
   logic                 rsp_valid_ff,  rsp_valid_in;

   // datapath registers
   logic signed [SAMPLE_W-1:0] cand_ff,   cand_in;
   logic signed [SAMPLE_W-1:0] median_ff, median_in;
   logic [CNT_W-1:0]           lt_ff,     lt_in;
   logic [CNT_W-1:0]           le_ff,     le_in;
   logic signed [SUM_W-1:0]    sum_ff,    sum_in;
   logic [CNT_W-1:0]           count_ff,  count_in;
   logic                       neg_ff,    neg_in;
   logic [SUM_W-1:0]           quo_ff,    quo_in;
   logic [CNT_W-1:0]           rem_ff,    rem_in;
   logic                       rsp_flag_ff, rsp_flag_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;

   logic                       accept;
   logic signed [SAMPLE_W-1:0] sample;
   logic signed [SAMPLE_W-1:0] head;
   win_ctl_type                win_ctl;
   logic signed [DIFF_W-1:0]   op_a;
   logic signed [DIFF_W-1:0]   op_b;
   alu_res_type                alu_res;
   logic [REM_W-1:0]           trial;
   logic [SUM_W-1:0]           quo_final;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign sample     = signed'(req_tdata);

   // the window shifts on every accepted sample and rotates once per rank or gate step;
   // both the rank and the gate phase end on a whole number of turns
   assign win_ctl.shift_in = accept;
   assign win_ctl.rotate   = (state_ff == ST_RANK) || (state_ff == ST_GATE);

   mgwa_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock     (clock),
      .ctl       (win_ctl),
      .sample_in (sample),
      .head      (head)
   );

   // restoring divide: next partial remainder candidate
   assign trial = {rem_ff, quo_ff[SUM_W-1]};

   // operand select for the shared subtractor
   always_comb begin
      unique case (state_ff)
         ST_RANK: begin
            op_a = DIFF_W'(head);
            op_b = DIFF_W'(cand_ff);
         end
         ST_GATE: begin
            op_a = DIFF_W'(head);
            op_b = DIFF_W'(median_ff);
         end
         ST_DIV: begin
            op_a = DIFF_W'(trial);
            op_b = DIFF_W'(count_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   mgwa_alu u_alu (
      .op_a (op_a),
      .op_b (op_b),
      .res  (alu_res)
   );

   assign quo_final = neg_ff ? SUM_W'(-quo_ff) : quo_ff;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      full_in       = full_ff;
      pass_in       = pass_ff;
      step_in       = step_ff;
      dstep_in      = dstep_ff;
      held_valid_in = held_valid_ff;
      held_value_in = held_value_ff;
      max_dev_in    = csr_wr_en ? csr_wr_data : max_dev_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cand_in       = cand_ff;
      median_in     = median_ff;
      lt_in         = lt_ff;
      le_in         = le_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      neg_in        = neg_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!full_ff) begin
                  // filling: store only, return the held result
                  if (fill_ff == PASS_W'(WINDOW - 1)) begin
                     fill_in = '0;
                     full_in = 1'b1;
                  end else begin
                     fill_in = fill_ff + 1'b1;
                  end
                  state_in = ST_OUT;
               end else begin
                  pass_in  = '0;
                  step_in  = '0;
                  state_in = ST_RANK;
               end
            end
         end

         ST_RANK: begin
            // per candidate: latch it, compare against the others, then one spare
            // rotate so the next pass starts on the next element
            if (step_ff == '0) begin
               cand_in = head;
               lt_in   = '0;
               le_in   = CNT_W'(1);
               step_in = step_ff + 1'b1;
            end else if (step_ff < STEP_W'(WINDOW)) begin
               if (alu_res.neg) begin
                  lt_in = lt_ff + 1'b1;
               end
               if (alu_res.neg || alu_res.zero) begin
                  le_in = le_ff + 1'b1;
               end
               step_in = step_ff + 1'b1;
            end else begin
               // candidate sits at the middle rank of the sorted window
               if (lt_ff <= CNT_W'(MID) && le_ff > CNT_W'(MID)) begin
                  median_in = cand_ff;
               end
               step_in = '0;
               if (pass_ff == PASS_W'(WINDOW - 1)) begin
                  pass_in  = '0;
                  sum_in   = '0;
                  count_in = '0;
                  state_in = ST_GATE;
               end else begin
                  pass_in = pass_ff + 1'b1;
               end
            end
         end

         ST_GATE: begin
            if (alu_res.mag < max_dev_ff) begin
               sum_in   = sum_ff + SUM_W'(head);
               count_in = count_ff + 1'b1;
            end
            if (step_ff == STEP_W'(WINDOW - 1)) begin
               step_in  = '0;
               state_in = ST_DIV_SETUP;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end

         ST_DIV_SETUP: begin
            if (count_ff == '0) begin
               // every sample rejected
               held_valid_in = 1'b0;
               held_value_in = '0;
               state_in      = ST_OUT;
            end else begin
               neg_in   = sum_ff[SUM_W-1];
               quo_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
               rem_in   = '0;
               dstep_in = '0;
               state_in = ST_DIV;
            end
         end

         ST_DIV: begin
            // one quotient bit per cycle, magnitude divided by count
            rem_in = alu_res.neg ? trial[CNT_W-1:0] : alu_res.diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], !alu_res.neg};
            if (dstep_ff == DSTEP_W'(SUM_W - 1)) begin
               state_in = ST_DIV_FIX;
            end else begin
               dstep_in = dstep_ff + 1'b1;
            end
         end

         ST_DIV_FIX: begin
            // truncation toward zero: sign applied to the magnitude quotient
            held_valid_in = 1'b1;
            held_value_in = quo_final[SAMPLE_W-1:0];
            state_in      = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = held_valid_ff;
               rsp_data_in  = held_value_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         full_ff       <= 1'b0;
         pass_ff       <= '0;
         step_ff       <= '0;
         dstep_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_value_ff <= '0;
         max_dev_ff    <= MAX_DEV_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         full_ff       <= full_in;
         pass_ff       <= pass_in;
         step_ff       <= step_in;
         dstep_ff      <= dstep_in;
         held_valid_ff <= held_valid_in;
         held_value_ff <= held_value_in;
         max_dev_ff    <= max_dev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cand_ff     <= cand_in;
      median_ff   <= median_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      sum_ff      <= sum_in;
      count_ff    <= count_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      rsp_flag_ff <= rsp_flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_flag_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/mgwa_alu.sv]
// shared subtractor with sign, zero and magnitude flags
module mgwa_alu import mgwa_pkg::*; (
   input  logic signed [DIFF_W-1:0] op_a,
   input  logic signed [DIFF_W-1:0] op_b,
   output alu_res_type              res
);

   logic signed [DIFF_W-1:0] diff;
   logic        [DIFF_W-1:0] abs_v;

   assign diff  = op_a - op_b;
   assign abs_v = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;

   // |a - b| of two 16-bit samples never exceeds 65535
   assign res.neg  = diff[DIFF_W-1];
   assign res.zero = (diff == '0);
   assign res.mag  = abs_v[SAMPLE_W-1:0];
   assign res.diff = diff;

endmodule

[rtl/mgwa_window.sv]
// sample window as a circular shift line read at its head
module mgwa_window import mgwa_pkg::*; #(
   parameter int WINDOW = 7
) (
   input  logic                       clock,
   input  win_ctl_type                ctl,
   input  logic signed [SAMPLE_W-1:0] sample_in,
   output logic signed [SAMPLE_W-1:0] head
);

   logic signed [SAMPLE_W-1:0] win_ff [WINDOW];
   logic signed [SAMPLE_W-1:0] tail_in;

   // new sample drops the oldest, rotate moves the head to the tail
   assign tail_in = ctl.shift_in ? sample_in : win_ff[0];

   always_ff @(posedge clock) begin
      if (ctl.shift_in || ctl.rotate) begin
         for (int k = 0; k < WINDOW - 1; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[WINDOW-1] <= tail_in;
      end
   end

   assign head = win_ff[0];

endmodule

[rtl/mgwa_checker.sv]
// port level checks for the median gated window average, bound to the top level
module mgwa_checker import mgwa_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [SAMPLE_W-1:0] rsp_tdata,
   input logic                rsp_tuser
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_tvalid)
      else $error("rsp beat presented right after reset");

   // an invalid result always carries zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid result with nonzero value");

   // one sample at a time: busy right after taking a beat
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req beat taken while previous sample in work");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

endmodule

bind median_gated_window_average mgwa_checker u_mgwa_checker (.*);

[bench/mgwa_result_checker.sv]
// result checker: tracks the limit register, predicts each smoothed value and compares rsp beats
module mgwa_result_checker import mgwa_pkg::*; #(
   parameter int WINDOW = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [SAMPLE_W-1:0] req_tdata,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [SAMPLE_W-1:0] rsp_tdata,
   input  logic                rsp_tuser,
   input  logic                csr_wr_en,
   input  logic [SAMPLE_W-1:0] csr_wr_data,
   output int                  fail_count,
   output int                  pending_count,
   output int                  checked_count,
   output int                  valid_count
);

   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] value;
   } smoothed_type;

   logic signed [SAMPLE_W-1:0] window_q [WINDOW];
   int                         fill_level;
   logic                       window_full;
   smoothed_type               held;
   logic        [SAMPLE_W-1:0] dev_limit;
   smoothed_type               expected_smoothed [$];
   smoothed_type               oldest;
   int                         fails   = 0;
   int                         checks  = 0;
   int                         valids  = 0;

   // mean of the window samples that lie closer than dev_limit to the median
   function automatic smoothed_type gated_mean();
      int           ranked [WINDOW];
      int           key, j, median, dev, sum, cnt;
      smoothed_type r;
      for (int i = 0; i < WINDOW; i++) ranked[i] = int'(window_q[i]);
      for (int i = 1; i < WINDOW; i++) begin
         key = ranked[i];
         j   = i - 1;
         while (j >= 0 && ranked[j] > key) begin
            ranked[j+1] = ranked[j];
            j--;
         end
         ranked[j+1] = key;
      end
      median = ranked[WINDOW/2];
      sum = 0;
      cnt = 0;
      for (int i = 0; i < WINDOW; i++) begin
         dev = int'(window_q[i]) - median;
         if (dev < 0) dev = -dev;
         if (dev < int'(dev_limit)) begin
            sum += int'(window_q[i]);
            cnt++;
         end
      end
      r = '0;
      if (cnt > 0) begin
         r.valid = 1'b1;
         r.value = SAMPLE_W'(sum / cnt);
      end
      return r;
   endfunction

   function automatic smoothed_type predict_smoothed(input logic signed [SAMPLE_W-1:0] s);
      if (!window_full) begin
         window_q[fill_level] = s;
         fill_level++;
         if (fill_level >= WINDOW) begin
            fill_level  = 0;
            window_full = 1'b1;
         end
      end else begin
         for (int i = 1; i < WINDOW; i++) window_q[i-1] = window_q[i];
         window_q[WINDOW-1] = s;
         held = gated_mean();
      end
      return held;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill_level  = 0;
         window_full = 1'b0;
         held        = '0;
         dev_limit   = MAX_DEV_RESET;
         expected_smoothed.delete();
      end else begin
         if (csr_wr_en) dev_limit = csr_wr_data;
         // compare before queuing, so a beat can never match its own sample
         if (rsp_tvalid && rsp_tready) begin
            if (expected_smoothed.size() == 0) begin
               fails++;
               $display("%0t: unexpected rsp beat, expected none, got valid %0b value %0d",
                        $time, rsp_tuser, $signed(rsp_tdata));
            end else begin
               oldest = expected_smoothed.pop_front();
               checks++;
               if (rsp_tuser) valids++;
               if (rsp_tuser !== oldest.valid) begin
                  fails++;
                  $display("%0t: result_valid mismatch, expected %0b, got %0b",
                           $time, oldest.valid, rsp_tuser);
               end
               if (rsp_tdata !== oldest.value) begin
                  fails++;
                  $display("%0t: smoothed_value mismatch, expected %0d, got %0d",
                           $time, oldest.value, $signed(rsp_tdata));
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_smoothed.push_back(predict_smoothed(req_tdata));
      end
      fail_count    <= fails;
      pending_count <= expected_smoothed.size();
      checked_count <= checks;
      valid_count   <= valids;
   end

endmodule

[bench/median_gated_window_average_tb.sv]
// testbench top: drives samples, limit writes and rsp back-pressure, then reports the verdict
module median_gated_window_average_tb;
   import mgwa_pkg::*;

   localparam int WINDOW        = 7;
   // one long rsp hold-off, in cycles after reset release
   localparam int HOLD_START    = 20000;
   localparam int HOLD_CYCLES   = 800;
   // comfortably above a full-window evaluation
   localparam int SETTLE_CYCLES = 120;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata   = '0;    // [15:0] sample
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b1;
   logic [SAMPLE_W-1:0] rsp_tdata;           // [15:0] smoothed_value
   logic                rsp_tuser;           // [0] result_valid
   logic                csr_wr_en   = 1'b0;
   logic [SAMPLE_W-1:0] csr_wr_data = '0;    // [15:0] max_deviation

   int fail_count, pending_count, checked_count, valid_count;
   int burst_left     = 0;
   int samples_sent   = 0;
   int limit_writes   = 0;
   int receiver_cycle = 0;
   int stall_mode     = 0;

   always #10 clock = ~clock;

   median_gated_window_average #(.WINDOW(WINDOW)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   mgwa_result_checker #(.WINDOW(WINDOW)) results_chk (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .valid_count   (valid_count)
   );

   // offer one sample and hold it until the beat is taken
   // samples go out in bursts; a gap only opens when a burst is used up, so
   // tvalid is never dropped and raised within the same edge
   task automatic send_sample(input logic [SAMPLE_W-1:0] s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         // mostly short gaps, sometimes long enough to span a whole evaluation
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      samples_sent++;
   endtask

   // drop tvalid and wait until every sample in flight has its result back
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      // one edge first so a beat taken on this edge shows up in pending_count
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // single cycle limit write, only with the block drained
   task automatic write_limit(input logic [SAMPLE_W-1:0] limit);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_writes++;
   endtask

   // receiver: switches among random stall patterns, with one long
   // hold-off so the pending result blocks the output and req_tready drops
   initial begin
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         receiver_cycle++;
         if (receiver_cycle % 256 == 0) stall_mode = $urandom_range(0, 3);
         if (receiver_cycle >= HOLD_START && receiver_cycle < HOLD_START + HOLD_CYCLES)
            rsp_tready <= 1'b0;
         else begin
            case (stall_mode)
               0:       rsp_tready <= 1'b1;                          // no stalls
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= ($urandom_range(0, 3) == 0);   // mostly stalled
               default: rsp_tready <= (receiver_cycle % 4 != 0);
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [SAMPLE_W-1:0]        fill_set [7];
      logic [SAMPLE_W-1:0]        near_zero [5];
      logic [SAMPLE_W-1:0]        limit;
      logic signed [SAMPLE_W-1:0] rnd16;
      int                         center, spread, pick, v;

      // fill with the extremes and alternating bit patterns
      fill_set  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA};
      near_zero = '{16'd5, 16'hFFFD, 16'd7, 16'd0, 16'hFFFE};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill phase under the reset limit: every result is the held invalid zero,
      // including the sample that completes the window
      foreach (fill_set[i]) send_sample(fill_set[i]);
      // first evaluations, median near zero with the extremes as outliers
      foreach (near_zero[i]) send_sample(near_zero[i]);

      // limit 0 rejects every sample
      write_limit(16'd0);
      send_sample(16'd0);
      send_sample(16'd0);

      // widest limit 65535: the rails pass the gate against a median near zero
      write_limit(16'hFFFF);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h8000);

      // limit 1 keeps only exact matches of the median
      write_limit(16'd1);
      repeat (4) send_sample(16'd1234);

      // random phases: a cluster around a random center with a random spread,
      // some far outliers and some fully random samples
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       limit = 16'd0;
            1:       limit = 16'hFFFF;
            default: begin
               case ($urandom_range(0, 2))
                  0:       limit = SAMPLE_W'($urandom_range(1, 15));
                  1:       limit = SAMPLE_W'($urandom_range(16, 4095));
                  default: limit = SAMPLE_W'($urandom_range(4096, 65535));
               endcase
            end
         endcase
         write_limit(limit);
         rnd16  = SAMPLE_W'($urandom);
         center = int'(rnd16);
         spread = 1 << $urandom_range(0, 12);
         repeat (120) begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
               v = center + int'($urandom_range(0, 2 * spread)) - spread;
            else if (pick < 90)
               v = center + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1000, 40000));
            else begin
               rnd16 = SAMPLE_W'($urandom);
               v     = int'(rnd16);
            end
            // clamping also makes the rails frequent
            if (v > 32767) v = 32767;
            else if (v < -32768) v = -32768;
            send_sample(v[SAMPLE_W-1:0]);
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d samples, %0d results checked (%0d valid), %0d limit writes incl. 0 and 65535",
               samples_sent, checked_count, valid_count, limit_writes);
      $display("one rsp hold-off of %0d cycles with the sender still offering samples",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("** median_gated_window_average: PASSED **");
      else
         $display("** median_gated_window_average: FAILED **");
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20000000;
      $display("** median_gated_window_average: FAILED **");
      $finish;
   end

endmodule

[median_gated_window_average.f]
rtl/mgwa_pkg.sv
rtl/mgwa_alu.sv
rtl/mgwa_window.sv
rtl/median_gated_window_average.sv
rtl/mgwa_checker.sv
bench/mgwa_result_checker.sv
bench/median_gated_window_average_tb.sv
